// ===== src/trc_pkg.sv =====
// trc_pkg: shared types and constants of the timed relay override controller
// no dependencies; used by every module of the block
`default_nettype none

package trc_pkg;

  // command codes, codes above CMD_QUERY behave as a query
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_ON_FOR    = 3'd1;
  localparam logic [2:0] CMD_FORCE_ON  = 3'd2;
  localparam logic [2:0] CMD_FORCE_OFF = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;
  localparam logic [2:0] CMD_QUERY     = 3'd5;

  // override modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_RELAY_COUNT  = 2'd0;
  localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd1;
  localparam logic [1:0] REG_TICK_RATE    = 2'd2;

  localparam int TIME_W  = 64;
  localparam int SECS_W  = 32;
  localparam int RATE_W  = 20;
  localparam int SPAN_W  = SECS_W + RATE_W;
  localparam int CFG_W   = 20;
  localparam int LVL_W   = 8;
  localparam int STEP_W  = 6;  // counts the 64 quotient bits

  localparam logic [3:0]        RESET_RELAY_COUNT = 4'd8;
  localparam logic [RATE_W-1:0] RESET_TICK_RATE   = 20'd1000000;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] res;
    logic              carry;  // carry out for add, borrow for sub
  } alu_rsp_t;

  typedef struct packed {
    logic              timer_we;
    logic              running;
    logic [TIME_W-1:0] deadline;
    logic              mode_we;
    logic [1:0]        mode;
  } bank_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK,
    S_WALK,
    S_MUL,
    S_ADD,
    S_CMP,
    S_LEFT,
    S_DIV,
    S_ROUND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [7:0]        relay_index;
    logic [SECS_W-1:0] on_seconds;
  } in_item_t;

  typedef struct packed {
    logic              error_code;
    logic              timer_running_out;
    logic [1:0]        override_out;
    logic              relay_output_on;
    logic [SECS_W-1:0] secs_remaining;
    logic [LVL_W-1:0]  drive_levels;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/trc_alu.sv =====
// trc_alu: shared 64-bit add/subtract unit with carry or borrow out
// depends on trc_pkg
`default_nettype none

module trc_alu (
  input  wire trc_pkg::alu_req_t req,
  output trc_pkg::alu_rsp_t      rsp
);

  logic                      sub;
  logic [trc_pkg::TIME_W:0]  sum;

  assign sub = (req.op == trc_pkg::ALU_SUB);
  assign sum = {1'b0, req.a} + {1'b0, req.b ^ {trc_pkg::TIME_W{sub}}}
             + {{trc_pkg::TIME_W{1'b0}}, sub};

  assign rsp.res   = sum[trc_pkg::TIME_W-1:0];
  assign rsp.carry = sum[trc_pkg::TIME_W] ^ sub;

endmodule

`default_nettype wire

// ===== src/trc_relay_bank.sv =====
// trc_relay_bank: per-relay timer flag, deadline and override mode, pin levels
// depends on trc_pkg
`default_nettype none

module trc_relay_bank #(
  parameter int MAX_RELAYS = 8,
  parameter int RIDX_W     = 3,
  parameter int CNT_W      = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [RIDX_W-1:0]             sel,
  input  wire trc_pkg::bank_wr_t             wr,
  input  wire logic [CNT_W-1:0]              used_n,
  input  wire logic                          on_level,
  output logic                               rd_running,
  output logic [1:0]                         rd_mode,
  output logic [trc_pkg::TIME_W-1:0]         rd_deadline,
  output logic                               rd_on,
  output logic [trc_pkg::LVL_W-1:0]          levels
);

  logic [MAX_RELAYS-1:0]     running_r;
  logic [1:0]                mode_r     [MAX_RELAYS];
  logic [trc_pkg::TIME_W-1:0] deadline_r [MAX_RELAYS];
  logic [MAX_RELAYS-1:0]     on_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      for (int i = 0; i < MAX_RELAYS; i++) begin
        mode_r[i] <= trc_pkg::MODE_NONE;
      end
    end else begin
      if (wr.timer_we) begin
        running_r[sel] <= wr.running;
      end
      if (wr.mode_we) begin
        mode_r[sel] <= wr.mode;
      end
    end
  end

  // deadline is only looked at while its timer runs
  always_ff @(posedge clk) begin
    if (wr.timer_we) begin
      deadline_r[sel] <= wr.deadline;
    end
  end

  // driven state follows override, else the timer
  always_comb begin
    for (int i = 0; i < MAX_RELAYS; i++) begin
      on_w[i] = (mode_r[i] == trc_pkg::MODE_ON) ||
                ((mode_r[i] == trc_pkg::MODE_NONE) && running_r[i]);
    end
  end

  assign rd_running  = running_r[sel];
  assign rd_mode     = mode_r[sel];
  assign rd_deadline = deadline_r[sel];
  assign rd_on       = on_w[sel];

  for (genvar g = 0; g < trc_pkg::LVL_W; g++) begin : g_lvl
    if (g < MAX_RELAYS) begin : g_used
      logic lit;
      assign lit       = (32'(g) < 32'(used_n)) && on_w[g];
      assign levels[g] = lit ? on_level : ~on_level;
    end else begin : g_none
      assign levels[g] = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/timed_relay_override_controller.sv =====
// timed_relay_override_controller: top level, sequencer around one shared adder
// depends on trc_pkg, trc_alu, trc_relay_bank
//
//   channel | ports                          | item
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data    | command, relay index, seconds
//   result  | out_valid, out_ready, out_data | one result per input item
//   config  | cfg_we, cfg_index, cfg_wdata   | register write, no wait
//
// one item at a time; a tick walks the relays in use, one compare per relay
// a query or command on a running timer runs the 64-step restoring division
// on the shared adder; on_for first steps through multiply, add and compare
// a result waits in the output register while the next item is taken
// reset is synchronous and active low, no clearing pass
`default_nettype none

module timed_relay_override_controller #(
  parameter int MAX_RELAYS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire trc_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output trc_pkg::out_item_t        out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [trc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int RIDX_W = (MAX_RELAYS > 1) ? $clog2(MAX_RELAYS) : 1;
  localparam int CNT_W  = $clog2(MAX_RELAYS + 1);
  localparam int TW     = trc_pkg::TIME_W;
  localparam int RW     = trc_pkg::RATE_W;
  localparam int SW     = trc_pkg::SPAN_W;

  // configuration registers
  logic [3:0]    count_cfg_r;
  logic          level_cfg_r;
  logic [RW-1:0] rate_cfg_r;

  // sequencer and datapath registers
  trc_pkg::state_t state_r, state_nxt;
  logic [2:0]                  cmd_r,    cmd_nxt;
  logic [7:0]                  idx_r,    idx_nxt;
  logic [trc_pkg::SECS_W-1:0]  secs_r,   secs_nxt;
  logic [TW-1:0]               time_r,   time_nxt;
  logic [trc_pkg::SPAN_W-1:0]  span_r,   span_nxt;
  logic [TW-1:0]               want_r,   want_nxt;
  logic [TW-1:0]               left_r,   left_nxt;   // dividend, then quotient
  logic [RW-1:0]               rem_r,    rem_nxt;
  logic [trc_pkg::STEP_W-1:0]  step_r,   step_nxt;
  logic [CNT_W-1:0]            walk_r,   walk_nxt;
  logic [trc_pkg::SECS_W-1:0]  remain_r, remain_nxt;
  logic                        err_r,    err_nxt;
  logic                        tick_r,   tick_nxt;
  logic                        out_valid_r, out_valid_nxt;
  trc_pkg::out_item_t          out_r,    out_nxt;

  // shared unit and relay bank hookup
  trc_pkg::alu_req_t alu_req;
  trc_pkg::alu_rsp_t alu_rsp;
  trc_pkg::bank_wr_t bank_wr;
  logic [RIDX_W-1:0] sel;
  logic              rd_running;
  logic [1:0]        rd_mode;
  logic [TW-1:0]     rd_deadline;
  logic              rd_on;
  logic [trc_pkg::LVL_W-1:0] levels;

  // derived values
  logic [CNT_W-1:0]  used_n;
  logic [RW-1:0]     rate_eff;
  logic [7:0]        idx_m1;
  logic [RIDX_W-1:0] rel_idx;
  logic              idx_ok;
  logic              is_tick;
  logic              walk_end;
  logic              out_free;
  logic              none_left;
  logic [RW:0]       div_shift;
  logic [trc_pkg::SECS_W:0] ceil_sum;

  // counts above the relay capacity clamp to it
  assign used_n   = (32'(count_cfg_r) > 32'(MAX_RELAYS)) ? CNT_W'(MAX_RELAYS)
                                                         : CNT_W'(count_cfg_r);
  assign rate_eff = (rate_cfg_r == '0) ? RW'(1) : rate_cfg_r;
  assign idx_m1   = idx_r - 8'd1;
  assign rel_idx  = idx_m1[RIDX_W-1:0];
  assign idx_ok   = (idx_r != 8'd0) && (32'(idx_r) <= 32'(used_n));
  assign is_tick  = (cmd_r == trc_pkg::CMD_TICK);
  assign walk_end = (walk_r == used_n);
  assign out_free = !out_valid_r || out_ready;
  // timer off, or deadline already at or before now
  assign none_left = !rd_running || alu_rsp.carry || (alu_rsp.res == '0);
  assign div_shift = {rem_r, left_r[TW-1]};
  assign ceil_sum  = {1'b0, left_r[trc_pkg::SECS_W-1:0]}
                   + {{trc_pkg::SECS_W{1'b0}}, (rem_r != '0)};

  trc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  trc_relay_bank #(
    .MAX_RELAYS (MAX_RELAYS),
    .RIDX_W     (RIDX_W),
    .CNT_W      (CNT_W)
  ) u_bank (
    .clk          (clk),
    .rst_n        (rst_n),
    .sel          (sel),
    .wr           (bank_wr),
    .used_n       (used_n),
    .on_level     (level_cfg_r),
    .rd_running   (rd_running),
    .rd_mode      (rd_mode),
    .rd_deadline  (rd_deadline),
    .rd_on        (rd_on),
    .levels       (levels)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = trc_pkg::S_DECODE;
      end
      trc_pkg::S_DECODE: begin
        if (is_tick) begin
          state_nxt = trc_pkg::S_TICK;
        end else if (!idx_ok) begin
          state_nxt = trc_pkg::S_DONE;
        end else if (cmd_r == trc_pkg::CMD_ON_FOR) begin
          state_nxt = trc_pkg::S_MUL;
        end else begin
          state_nxt = trc_pkg::S_LEFT;
        end
      end
      trc_pkg::S_TICK:  state_nxt = trc_pkg::S_WALK;
      trc_pkg::S_WALK: begin
        if (walk_end) state_nxt = trc_pkg::S_DONE;
      end
      trc_pkg::S_MUL:   state_nxt = trc_pkg::S_ADD;
      trc_pkg::S_ADD:   state_nxt = trc_pkg::S_CMP;
      trc_pkg::S_CMP:   state_nxt = trc_pkg::S_LEFT;
      trc_pkg::S_LEFT: begin
        state_nxt = none_left ? trc_pkg::S_DONE : trc_pkg::S_DIV;
      end
      trc_pkg::S_DIV: begin
        if (step_r == '1) state_nxt = trc_pkg::S_ROUND;
      end
      trc_pkg::S_ROUND: state_nxt = trc_pkg::S_DONE;
      trc_pkg::S_DONE: begin
        if (out_free) state_nxt = trc_pkg::S_IDLE;
      end
      default:          state_nxt = trc_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: shared unit operands, bank access, input ready
  always_comb begin
    in_ready    = 1'b0;
    alu_req.op  = trc_pkg::ALU_ADD;
    alu_req.a   = '0;
    alu_req.b   = '0;
    bank_wr     = '0;
    sel         = rel_idx;
    case (state_r)
      trc_pkg::S_IDLE: in_ready = 1'b1;
      trc_pkg::S_DECODE: begin
        if (!is_tick && idx_ok) begin
          case (cmd_r)
            trc_pkg::CMD_FORCE_ON: begin
              bank_wr.mode_we = 1'b1;
              bank_wr.mode    = trc_pkg::MODE_ON;
            end
            trc_pkg::CMD_FORCE_OFF: begin
              bank_wr.mode_we = 1'b1;
              bank_wr.mode    = trc_pkg::MODE_OFF;
            end
            trc_pkg::CMD_CLEAR: begin
              bank_wr.mode_we = 1'b1;
              bank_wr.mode    = trc_pkg::MODE_NONE;
            end
            default: bank_wr.mode_we = 1'b0;
          endcase
        end
      end
      trc_pkg::S_TICK: begin
        alu_req.a = time_r;
        alu_req.b = TW'(1);
      end
      trc_pkg::S_WALK: begin
        // no borrow from now - deadline: deadline reached
        sel        = walk_r[RIDX_W-1:0];
        alu_req.op = trc_pkg::ALU_SUB;
        alu_req.a  = time_r;
        alu_req.b  = rd_deadline;
        if (!walk_end && rd_running && !alu_rsp.carry) begin
          bank_wr.timer_we = 1'b1;
        end
      end
      trc_pkg::S_ADD: begin
        alu_req.a = time_r;
        alu_req.b = TW'(span_r);
      end
      trc_pkg::S_CMP: begin
        // keep the later deadline of a running timer; zero seconds stops the timer
        alu_req.op       = trc_pkg::ALU_SUB;
        alu_req.a        = want_r;
        alu_req.b        = rd_deadline;
        bank_wr.timer_we = 1'b1;
        bank_wr.running  = (secs_r != '0);
        if (secs_r != '0) begin
          bank_wr.deadline = (rd_running && alu_rsp.carry) ? rd_deadline : want_r;
        end
      end
      trc_pkg::S_LEFT: begin
        alu_req.op = trc_pkg::ALU_SUB;
        alu_req.a  = rd_deadline;
        alu_req.b  = time_r;
      end
      trc_pkg::S_DIV: begin
        alu_req.op = trc_pkg::ALU_SUB;
        alu_req.a  = TW'(div_shift);
        alu_req.b  = TW'(rate_eff);
      end
      default: in_ready = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    secs_nxt      = secs_r;
    time_nxt      = time_r;
    span_nxt      = span_r;
    want_nxt      = want_r;
    left_nxt      = left_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    walk_nxt      = walk_r;
    remain_nxt    = remain_r;
    err_nxt       = err_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      trc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          idx_nxt  = in_data.relay_index;
          secs_nxt = in_data.on_seconds;
        end
      end
      trc_pkg::S_DECODE: begin
        tick_nxt   = is_tick;
        err_nxt    = !is_tick && !idx_ok;
        remain_nxt = '0;
        walk_nxt   = '0;
      end
      // time saturates at its maximum
      trc_pkg::S_TICK: time_nxt = alu_rsp.carry ? '1 : alu_rsp.res;
      trc_pkg::S_WALK: begin
        if (!walk_end) walk_nxt = walk_r + CNT_W'(1);
      end
      trc_pkg::S_MUL:  span_nxt = SW'(secs_r) * SW'(rate_eff);
      trc_pkg::S_ADD:  want_nxt = alu_rsp.carry ? '1 : alu_rsp.res;
      trc_pkg::S_LEFT: begin
        left_nxt   = alu_rsp.res;
        rem_nxt    = '0;
        step_nxt   = '0;
        remain_nxt = '0;
      end
      trc_pkg::S_DIV: begin
        // restoring step, quotient bit shifts in behind the dividend
        if (!alu_rsp.carry) begin
          rem_nxt  = alu_rsp.res[RW-1:0];
          left_nxt = {left_r[TW-2:0], 1'b1};
        end else begin
          rem_nxt  = div_shift[RW-1:0];
          left_nxt = {left_r[TW-2:0], 1'b0};
        end
        step_nxt = step_r + trc_pkg::STEP_W'(1);
      end
      trc_pkg::S_ROUND: begin
        // round up, saturate to 32 bits
        if ((left_r[TW-1:trc_pkg::SECS_W] != '0) || ceil_sum[trc_pkg::SECS_W]) begin
          remain_nxt = '1;
        end else begin
          remain_nxt = ceil_sum[trc_pkg::SECS_W-1:0];
        end
      end
      trc_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_nxt.error_code        = err_r;
          out_nxt.drive_levels      = levels;
          if (tick_r || err_r) begin
            out_nxt.timer_running_out = 1'b0;
            out_nxt.override_out      = trc_pkg::MODE_NONE;
            out_nxt.relay_output_on   = 1'b0;
            out_nxt.secs_remaining    = '0;
          end else begin
            out_nxt.timer_running_out = rd_running;
            out_nxt.override_out      = rd_mode;
            out_nxt.relay_output_on   = rd_on;
            out_nxt.secs_remaining    = remain_r;
          end
        end
      end
      default: out_valid_nxt = out_valid_nxt;
    endcase
  end

  // control state and time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      time_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      time_r      <= time_nxt;
    end
  end

  // configuration writes, an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_cfg_r <= trc_pkg::RESET_RELAY_COUNT;
      level_cfg_r <= 1'b1;
      rate_cfg_r  <= trc_pkg::RESET_TICK_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        trc_pkg::REG_RELAY_COUNT:  count_cfg_r <= cfg_wdata[3:0];
        trc_pkg::REG_ACTIVE_LEVEL: level_cfg_r <= cfg_wdata[0];
        trc_pkg::REG_TICK_RATE:    rate_cfg_r  <= cfg_wdata[RW-1:0];
        default:                   count_cfg_r <= count_cfg_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    secs_r   <= secs_nxt;
    span_r   <= span_nxt;
    want_r   <= want_nxt;
    left_r   <= left_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    walk_r   <= walk_nxt;
    remain_r <= remain_nxt;
    err_r    <= err_nxt;
    tick_r   <= tick_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== src/trc_checker.sv =====
// trc_checker: port-level checks of the timed relay override controller
// depends on trc_pkg; bound to timed_relay_override_controller
`default_nettype none

module trc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire trc_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // a bad relay index reports no relay fields
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code |->
      !out_data.timer_running_out && (out_data.override_out == trc_pkg::MODE_NONE) &&
      !out_data.relay_output_on && (out_data.secs_remaining == '0))
    else $error("error result carries relay fields");

  // time left only while a timer runs
  a_remain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.secs_remaining != '0) |-> out_data.timer_running_out)
    else $error("remaining time without running timer");

  // an on override decides the driven state
  a_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.override_out == trc_pkg::MODE_ON) |-> out_data.relay_output_on)
    else $error("forced on relay not driven");

endmodule

bind timed_relay_override_controller trc_checker u_trc_checker (.*);

`default_nettype wire
